### rtl/pcmdf_pkg.sv
// shared constants, codes and types of the pcm ping-pong dac feeder
package pcmdf_pkg;

  // bytes in one buffer half, a power of two from 16 to 256
  localparam int HALF_BYTES = 256;
  localparam int BUF_BYTES  = 2 * HALF_BYTES;
  localparam int ADDR_W     = $clog2(BUF_BYTES);
  localparam int OFF_W      = $clog2(HALF_BYTES);

  // four byte banks so one tick reads four consecutive bytes at once
  localparam int NUM_BANKS  = 4;
  localparam int ROW_W      = ADDR_W - 2;
  localparam int BANK_DEPTH = BUF_BYTES / NUM_BANKS;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam int WADDR_W = 9;
  localparam int CFG_W   = 2;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  localparam logic CFG_SIXTEEN_IDX = 1'b0;
  localparam logic CFG_CHAN_IDX    = 1'b1;

  localparam logic [1:0] CH_MONO   = 2'd1;
  localparam logic [1:0] CH_STEREO = 2'd2;

  localparam logic [7:0] SIGN_FLIP = 8'h80;

  typedef struct packed {
    logic       sixteen;
    logic [1:0] chan;
  } cfg_t;

  // one tick on its way from the front to the back
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic            sixteen;
    logic            stereo;
    logic            play;
    logic            half;
    logic            finished;
    logic [2:0]      atten;
  } tick_t;

endpackage

### rtl/pcm_pingpong_dac_feeder_top.sv
// top level of the pcm ping-pong dac feeder
//
// in_* takes items: in_tuser 0 writes in_tdata's byte into the two-half
// sample buffer, in_tuser 1 is a sample tick. A tick may carry a volume
// reading, whose top three bits become the right-shift attenuation, then
// plays one frame (8 or 16 bit, mono or stereo) from the active half and
// swaps halves when the read offset wraps. Writes give no result; every
// tick gives one result on out_*. cfg_* sets sample width and channel
// count; the user must write it only while the block is idle, and the
// block itself does not enforce this. One item is taken per cycle while
// in_tready is high. A tick's result passes the bank read registers,
// then the queue, then the result register. The byte buffer is four
// interleaved banks, so a frame of up to four bytes is read at once.
// A four-entry queue sits between the front and the result register;
// in_tready drops only when the queue and the tick in flight would fill
// it, so a stalled receiver lets up to five results back up.
// Reset (rst_n low at a clock edge) clears the playback position, the
// volume, the held word and the queue; buffer contents stay undefined
// until written.
module pcm_pingpong_dac_feeder_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [31:0]                   in_tdata,   // write_address, write_byte, adc_ready, adc_value
  input  logic                          in_tuser,   // req_type
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [23:0]                   out_tdata,  // dac_value, playing_half, half_finished, volume_shift
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [pcmdf_pkg::CFG_W-1:0]   cfg_wdata
);

  pcmdf_pkg::cfg_t              cfg_r;
  pcmdf_pkg::tick_t             push_entry, head;
  logic                         push_valid, head_valid, pop;
  logic [pcmdf_pkg::QCNT_W-1:0] q_count;
  logic                         in_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sixteen <= 1'b0;
      cfg_r.chan    <= pcmdf_pkg::CH_MONO;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pcmdf_pkg::CFG_SIXTEEN_IDX: cfg_r.sixteen <= cfg_wdata[0];
        pcmdf_pkg::CFG_CHAN_IDX:    cfg_r.chan    <= cfg_wdata;
        default:                    cfg_r         <= cfg_r;
      endcase
    end
  end

  // credit: room for the queued ticks plus the one in the bank read stage
  assign in_tready = ((pcmdf_pkg::QCNT_W + 1)'(q_count) + (pcmdf_pkg::QCNT_W + 1)'(push_valid))
                     < (pcmdf_pkg::QCNT_W + 1)'(pcmdf_pkg::QDEPTH);
  assign in_acc    = in_tvalid && in_tready;

  pcmdf_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_acc        (in_acc),
    .req_type      (in_tuser),
    .write_address (in_tdata[8:0]),
    .write_byte    (in_tdata[16:9]),
    .adc_ready     (in_tdata[17]),
    .adc_value     (in_tdata[29:18]),
    .cfg           (cfg_r),
    .push_valid    (push_valid),
    .push_entry    (push_entry)
  );

  pcmdf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push_valid),
    .push_entry (push_entry),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .count      (q_count)
  );

  pcmdf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push_valid && !pop) |-> (q_count < pcmdf_pkg::QCNT_W'(pcmdf_pkg::QDEPTH)))
    else $error("tick queue overflow");

  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser == pcmdf_pkg::REQ_WRITE)) |=> !push_valid)
    else $error("write item produced a result");

  a_tick_pushed: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser == pcmdf_pkg::REQ_TICK)) |=> push_valid)
    else $error("tick item lost before the queue");

endmodule

### rtl/pcmdf_front.sv
// front: takes items, owns the byte banks and the playback position
module pcmdf_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_acc,
  input  logic                          req_type,
  input  logic [pcmdf_pkg::WADDR_W-1:0] write_address,
  input  logic [7:0]                    write_byte,
  input  logic                          adc_ready,
  input  logic [11:0]                   adc_value,
  input  pcmdf_pkg::cfg_t               cfg,
  output logic                          push_valid,
  output pcmdf_pkg::tick_t              push_entry
);

  logic [pcmdf_pkg::OFF_W-1:0]  off_r, off_nxt;
  logic                         half_r, half_nxt;
  logic [2:0]                   atten_r, atten_nxt;
  logic [2:0]                   step;
  logic [pcmdf_pkg::OFF_W:0]    sum;
  logic                         wrap;
  logic                         tick, wr, wr_ok;
  logic [pcmdf_pkg::ADDR_W-1:0] base, wa;
  logic [7:0]                   rd_r [pcmdf_pkg::NUM_BANKS];
  logic                         s1_valid_r;
  logic                         s1_sixteen_r, s1_stereo_r, s1_play_r;
  logic                         s1_half_r, s1_fin_r;
  logic [2:0]                   s1_atten_r;
  logic [1:0]                   s1_rot_r;

  assign tick  = in_acc && (req_type == pcmdf_pkg::REQ_TICK);
  assign wr    = in_acc && (req_type == pcmdf_pkg::REQ_WRITE);
  assign wa    = pcmdf_pkg::ADDR_W'(write_address);
  assign wr_ok = 32'(write_address) < 32'(pcmdf_pkg::BUF_BYTES);

  always_comb begin
    unique case (cfg.chan)
      pcmdf_pkg::CH_MONO:   step = cfg.sixteen ? 3'd2 : 3'd1;
      pcmdf_pkg::CH_STEREO: step = cfg.sixteen ? 3'd4 : 3'd2;
      default:              step = 3'd0;
    endcase
  end

  assign sum  = {1'b0, off_r} + (pcmdf_pkg::OFF_W + 1)'(step);
  assign wrap = sum[pcmdf_pkg::OFF_W];
  assign base = {half_r, off_r};

  always_comb begin
    off_nxt   = off_r;
    half_nxt  = half_r;
    atten_nxt = atten_r;
    if (tick) begin
      off_nxt = sum[pcmdf_pkg::OFF_W-1:0];
      if (wrap) begin
        half_nxt = ~half_r;
      end
      if (adc_ready) begin
        atten_nxt = adc_value[11:9];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r      <= '0;
      half_r     <= 1'b0;
      atten_r    <= 3'd0;
      s1_valid_r <= 1'b0;
    end else begin
      off_r      <= off_nxt;
      half_r     <= half_nxt;
      atten_r    <= atten_nxt;
      s1_valid_r <= tick;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      s1_sixteen_r <= cfg.sixteen;
      s1_stereo_r  <= (cfg.chan == pcmdf_pkg::CH_STEREO);
      s1_play_r    <= (step != 3'd0);
      s1_half_r    <= half_nxt;
      s1_fin_r     <= (step != 3'd0) && wrap;
      s1_atten_r   <= atten_nxt;
      s1_rot_r     <= base[1:0];
    end
  end

  // each bank gives the one byte of the frame that falls in it
  for (genvar b = 0; b < pcmdf_pkg::NUM_BANKS; b++) begin : g_bank
    logic [7:0]                   mem [pcmdf_pkg::BANK_DEPTH];
    logic [1:0]                   kb;
    logic [pcmdf_pkg::ADDR_W-1:0] ab;

    assign kb = 2'(b) - base[1:0];
    assign ab = base + pcmdf_pkg::ADDR_W'(kb);

    always_ff @(posedge clk) begin
      if (wr && wr_ok && (wa[1:0] == 2'(b))) begin
        mem[wa[pcmdf_pkg::ADDR_W-1:2]] <= write_byte;
      end
      if (tick) begin
        rd_r[b] <= mem[ab[pcmdf_pkg::ADDR_W-1:2]];
      end
    end
  end

  // rotate bank outputs so byte k of the frame lands in lane k
  for (genvar k = 0; k < pcmdf_pkg::NUM_BANKS; k++) begin : g_lane
    assign push_entry.bytes[k] = rd_r[2'(s1_rot_r + 2'(k))];
  end

  assign push_valid          = s1_valid_r;
  assign push_entry.sixteen  = s1_sixteen_r;
  assign push_entry.stereo   = s1_stereo_r;
  assign push_entry.play     = s1_play_r;
  assign push_entry.half     = s1_half_r;
  assign push_entry.finished = s1_fin_r;
  assign push_entry.atten    = s1_atten_r;

endmodule

### rtl/pcmdf_queue.sv
// short fifo of ticks between front and back
module pcmdf_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  pcmdf_pkg::tick_t             push_entry,
  input  logic                         pop,
  output logic                         head_valid,
  output pcmdf_pkg::tick_t             head,
  output logic [pcmdf_pkg::QCNT_W-1:0] count
);

  pcmdf_pkg::tick_t             mem [pcmdf_pkg::QDEPTH];
  logic [pcmdf_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [pcmdf_pkg::QCNT_W-1:0] count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  assign head       = mem[rd_ptr_r];
  assign head_valid = (count_r != '0);
  assign count      = count_r;

endmodule

### rtl/pcmdf_back.sv
// back: forms the dac word, applies the volume and holds the result register
module pcmdf_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  pcmdf_pkg::tick_t head,
  output logic             pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [23:0]      out_tdata
);

  logic [7:0]  b0, b1, b2, b3;
  logic [11:0] mono8, st8, mono16, st16, word, shifted, dac;
  logic [12:0] st8_sum;
  logic [11:0] last_r;
  logic        out_valid_r, out_valid_nxt;
  logic [11:0] dac_r;
  logic        half_r, fin_r;
  logic [2:0]  vol_r;

  assign b0 = head.bytes[0];
  assign b1 = head.bytes[1];
  assign b2 = head.bytes[2];
  assign b3 = head.bytes[3];

  assign mono8   = {b0, 4'b0};
  assign st8_sum = {1'b0, b0, 3'b0} + {1'b0, b1, 3'b0};
  assign st8     = st8_sum[11:0];
  assign mono16  = {b1 ^ pcmdf_pkg::SIGN_FLIP, b0[7:4]};
  // 11-bit left plus 11-bit right
  assign st16    = {1'b0, b1 ^ pcmdf_pkg::SIGN_FLIP, b0[7:5]}
                 + {1'b0, b3 ^ pcmdf_pkg::SIGN_FLIP, b2[7:5]};

  always_comb begin
    unique case ({head.sixteen, head.stereo})
      2'b00:   word = mono8;
      2'b01:   word = st8;
      2'b10:   word = mono16;
      default: word = st16;
    endcase
  end

  assign shifted = word >> head.atten;
  // unsupported channel count repeats the held word
  assign dac     = head.play ? shifted : last_r;

  assign pop = head_valid && (!out_valid_r || out_tready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      last_r      <= 12'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        last_r <= dac;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      dac_r  <= dac;
      half_r <= head.half;
      fin_r  <= head.finished;
      vol_r  <= head.atten;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, vol_r, fin_r, half_r, dac_r};

endmodule

### tb/pcm_pingpong_dac_feeder_top_tb.sv
// self-checking testbench for the pcm ping-pong dac feeder: directed table, then random phases
`timescale 1ns / 100ps
module pcm_pingpong_dac_feeder_top_tb;

  localparam int CYCLE_LIMIT   = 100000;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [1:0] CH_NONE  = 2'd0;
  localparam logic [1:0] CH_THREE = 2'd3;

  typedef struct packed {
    logic [11:0] dac;
    logic        half;
    logic        finished;
    logic [2:0]  shift;
  } dac_word_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t                    kind;
    logic                         reg_idx;
    logic [pcmdf_pkg::CFG_W-1:0]  reg_val;
    logic                         req;
    logic [8:0]                   addr;
    logic [7:0]                   data;
    logic                         adc_rdy;
    logic [11:0]                  adc;
    logic                         typed;
    dac_word_t                    want;
  } stim_row_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_tvalid = 1'b0;
  logic                         in_tready;
  logic [31:0]                  in_tdata = '0;   // write_address, write_byte, adc_ready, adc_value
  logic                         in_tuser = 1'b0; // req_type
  logic                         out_tvalid;
  logic                         out_tready = 1'b0;
  logic [23:0]                  out_tdata;       // dac_value, playing_half, half_finished, volume_shift
  logic                         cfg_we = 1'b0;
  logic                         cfg_index = 1'b0;
  logic [pcmdf_pkg::CFG_W-1:0]  cfg_wdata = '0;

  // mirror of the block's playback state
  logic [7:0]  pcm_mem [pcmdf_pkg::BUF_BYTES];
  bit          pcm_written [pcmdf_pkg::BUF_BYTES];
  int unsigned play_off = 0;
  logic        play_half = 1'b0;
  logic [2:0]  vol_shift = 3'd0;
  logic [11:0] held_word = 12'd0;
  logic        cfg_sixteen = 1'b0;
  logic [1:0]  cfg_chan = pcmdf_pkg::CH_MONO;

  dac_word_t   pending_words[$];
  stim_row_t   directed_rows[$];
  int          err_count = 0;
  int unsigned cycle_count = 0;
  bit          in_eager = 1'b0;
  bit          out_eager = 1'b0;

  pcm_pingpong_dac_feeder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(string what);
    err_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic int frame_bytes();
    if (cfg_chan == pcmdf_pkg::CH_MONO) return cfg_sixteen ? 2 : 1;
    if (cfg_chan == pcmdf_pkg::CH_STEREO) return cfg_sixteen ? 4 : 2;
    return 0;
  endfunction

  function automatic int unsigned frame_addr(int k);
    return (int'(play_half) * pcmdf_pkg::HALF_BYTES + play_off + k) % pcmdf_pkg::BUF_BYTES;
  endfunction

  // plays one frame and returns the word the block should answer with
  function automatic dac_word_t play_tick(logic adc_rdy, logic [11:0] adc);
    int unsigned word, b0, b1, b2, b3;
    int          step;
    logic [11:0] w12;
    dac_word_t   res;
    if (adc_rdy) vol_shift = adc[11:9];
    step = frame_bytes();
    word = 0;
    res.finished = 1'b0;
    if (step != 0) begin
      b0 = pcm_mem[frame_addr(0)];
      b1 = (step > 1) ? pcm_mem[frame_addr(1)] : 0;
      b2 = (step > 2) ? pcm_mem[frame_addr(2)] : 0;
      b3 = (step > 3) ? pcm_mem[frame_addr(3)] : 0;
      if (cfg_sixteen && cfg_chan == pcmdf_pkg::CH_MONO)
        word = ((b1 ^ pcmdf_pkg::SIGN_FLIP) << 4) | (b0 >> 4);
      else if (cfg_sixteen)
        word = (((b1 ^ pcmdf_pkg::SIGN_FLIP) << 3) | (b0 >> 5))
             + (((b3 ^ pcmdf_pkg::SIGN_FLIP) << 3) | (b2 >> 5));
      else if (cfg_chan == pcmdf_pkg::CH_MONO)
        word = b0 << 4;
      else
        word = (b0 << 3) + (b1 << 3);
      w12 = word[11:0];
      held_word = w12 >> vol_shift;
      play_off += step;
      // offset wrap swaps halves
      if (play_off >= pcmdf_pkg::HALF_BYTES) begin
        play_off -= pcmdf_pkg::HALF_BYTES;
        play_half = ~play_half;
        res.finished = 1'b1;
      end
    end
    res.dac = held_word;
    res.half = play_half;
    res.shift = vol_shift;
    return res;
  endfunction

  function automatic void add_item(logic req, logic [8:0] addr, logic [7:0] data,
                                   logic adc_rdy, logic [11:0] adc, logic typed = 1'b0,
                                   dac_word_t want = '0);
    stim_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.req = req;
    row.addr = addr;
    row.data = data;
    row.adc_rdy = adc_rdy;
    row.adc = adc;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_reg(logic idx, logic [pcmdf_pkg::CFG_W-1:0] val);
    stim_row_t row;
    row = '0;
    row.kind = ROW_REG;
    row.reg_idx = idx;
    row.reg_val = val;
    directed_rows.push_back(row);
  endfunction

  task automatic send_item(logic req, logic [8:0] addr, logic [7:0] data, logic adc_rdy,
                           logic [11:0] adc, logic typed, dac_word_t want);
    int        gap;
    dac_word_t got;
    if ($urandom_range(0, 31) == 0) in_eager = ~in_eager;
    gap = in_eager ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= {2'b00, adc, adc_rdy, data, addr};
    do @(posedge clk); while (!in_tready);
    if (req == pcmdf_pkg::REQ_WRITE) begin
      pcm_mem[addr] = data;
      pcm_written[addr] = 1'b1;
    end else begin
      got = play_tick(adc_rdy, adc);
      pending_words.push_back(typed ? want : got);
    end
  endtask

  // wait for all results, then let the pipeline run dry
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [pcmdf_pkg::CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == pcmdf_pkg::CFG_SIXTEEN_IDX) cfg_sixteen = val[0];
    else cfg_chan = val;
  endtask

  task automatic run_phase(logic sixteen, logic [1:0] chan, int count);
    int         r, miss, nbytes;
    int unsigned base;
    logic [8:0] addr;
    drain();
    write_reg(pcmdf_pkg::CFG_SIXTEEN_IDX, {1'b0, sixteen});
    write_reg(pcmdf_pkg::CFG_CHAN_IDX, chan);
    repeat (count) begin
      base = frame_addr(0);
      r = $urandom_range(0, 99);
      if (r < 25) begin
        // mostly refill just ahead of the play position, sometimes anywhere
        if (r < 20) addr = 9'((base + $urandom_range(0, 31)) % pcmdf_pkg::BUF_BYTES);
        else addr = 9'($urandom_range(0, pcmdf_pkg::BUF_BYTES - 1));
        send_item(pcmdf_pkg::REQ_WRITE, addr, 8'($urandom), 1'($urandom), 12'($urandom),
                  1'b0, '0);
      end else begin
        // a tick may only read bytes that were written
        miss = -1;
        nbytes = frame_bytes();
        for (int k = 0; k < nbytes; k++)
          if (miss < 0 && !pcm_written[frame_addr(k)]) miss = frame_addr(k);
        if (miss >= 0)
          send_item(pcmdf_pkg::REQ_WRITE, 9'(miss), 8'($urandom), 1'($urandom),
                    12'($urandom), 1'b0, '0);
        else
          send_item(pcmdf_pkg::REQ_TICK, 9'($urandom), 8'($urandom),
                    $urandom_range(0, 3) == 0, 12'($urandom), 1'b0, '0);
      end
    end
  endtask

  initial begin : result_sink
    int        stall;
    dac_word_t got, want;
    wait (rst_n);
    forever begin
      if ($urandom_range(0, 31) == 0) out_eager = ~out_eager;
      stall = out_eager ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      if (!out_tready) out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got.dac = out_tdata[11:0];
      got.half = out_tdata[12];
      got.finished = out_tdata[13];
      got.shift = out_tdata[16:14];
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing expected", out_tdata));
      end else begin
        want = pending_words.pop_front();
        if (got.dac !== want.dac)
          report_mismatch($sformatf("dac_value %h, want %h", got.dac, want.dac));
        if (got.half !== want.half)
          report_mismatch($sformatf("playing_half %b, want %b", got.half, want.half));
        if (got.finished !== want.finished)
          report_mismatch($sformatf("half_finished %b, want %b", got.finished, want.finished));
        if (got.shift !== want.shift)
          report_mismatch($sformatf("volume_shift %0d, want %0d", got.shift, want.shift));
      end
    end
  end

  initial begin : stimulus
    logic [7:0] seed_bytes [11];
    stim_row_t  row;
    seed_bytes = '{8'hFF, 8'h80, 8'h7F, 8'h00, 8'hFF, 8'h5A, 8'hC3, 8'hE7, 8'h01, 8'hFE, 8'h80};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (seed_bytes[k])
      add_item(pcmdf_pkg::REQ_WRITE, 9'(k), seed_bytes[k], k[0], {12{k[0]}});
    add_item(pcmdf_pkg::REQ_WRITE, 9'h1FF, 8'hA5, 1'b1, 12'hFFF);
    // 8-bit mono from reset, full-scale byte
    add_item(pcmdf_pkg::REQ_TICK, 9'h000, 8'h00, 1'b0, 12'h000, 1'b1,
             '{12'hFF0, 1'b0, 1'b0, 3'd0});
    // largest volume shift on mid-scale
    add_item(pcmdf_pkg::REQ_TICK, 9'h1FF, 8'hFF, 1'b1, 12'hFFF, 1'b1,
             '{12'h010, 1'b0, 1'b0, 3'd7});
    add_item(pcmdf_pkg::REQ_TICK, 9'h000, 8'h00, 1'b1, 12'h1FF, 1'b1,
             '{12'h7F0, 1'b0, 1'b0, 3'd0});
    // unsupported channel counts hold the word but still take the volume
    add_reg(pcmdf_pkg::CFG_CHAN_IDX, CH_NONE);
    add_item(pcmdf_pkg::REQ_TICK, 9'h000, 8'h00, 1'b1, 12'hE00, 1'b1,
             '{12'h7F0, 1'b0, 1'b0, 3'd7});
    add_reg(pcmdf_pkg::CFG_CHAN_IDX, CH_THREE);
    add_item(pcmdf_pkg::REQ_TICK, 9'h000, 8'h00, 1'b0, 12'h000, 1'b1,
             '{12'h7F0, 1'b0, 1'b0, 3'd7});
    add_reg(pcmdf_pkg::CFG_CHAN_IDX, pcmdf_pkg::CH_STEREO);
    add_item(pcmdf_pkg::REQ_TICK, 9'h000, 8'h00, 1'b1, 12'h000);
    add_reg(pcmdf_pkg::CFG_SIXTEEN_IDX, 2'd1);
    add_reg(pcmdf_pkg::CFG_CHAN_IDX, pcmdf_pkg::CH_MONO);
    add_item(pcmdf_pkg::REQ_TICK, 9'h000, 8'h00, 1'b0, 12'h000);
    add_reg(pcmdf_pkg::CFG_CHAN_IDX, pcmdf_pkg::CH_STEREO);
    add_item(pcmdf_pkg::REQ_TICK, 9'h000, 8'h00, 1'b0, 12'h000);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_REG) begin
        drain();
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        send_item(row.req, row.addr, row.data, row.adc_rdy, row.adc, row.typed, row.want);
      end
    end

    run_phase(1'b1, pcmdf_pkg::CH_STEREO, 340);
    run_phase(1'b0, pcmdf_pkg::CH_MONO, 50);
    run_phase(1'b1, CH_NONE, 20);
    run_phase(1'b0, pcmdf_pkg::CH_STEREO, 70);
    run_phase(1'b1, pcmdf_pkg::CH_MONO, 70);
    run_phase(1'b0, CH_THREE, 20);
    run_phase(1'b1, pcmdf_pkg::CH_STEREO, 60);

    drain();
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### pcm_pingpong_dac_feeder_top.f
rtl/pcmdf_pkg.sv
rtl/pcmdf_front.sv
rtl/pcmdf_queue.sv
rtl/pcmdf_back.sv
rtl/pcm_pingpong_dac_feeder_top.sv
tb/pcm_pingpong_dac_feeder_top_tb.sv
